/* sv/bdq_pkg.sv */
package bdq_pkg;

	// Request codes carried in the kind field. Codes six and seven are no-ops.
	localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
	localparam logic [2:0] KIND_PUSH_BACK  = 3'd1;
	localparam logic [2:0] KIND_POP_FRONT  = 3'd2;
	localparam logic [2:0] KIND_POP_BACK   = 3'd3;
	localparam logic [2:0] KIND_SEARCH     = 3'd4;
	localparam logic [2:0] KIND_CLEAR      = 3'd5;

	// Result status codes.
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] data_in;
	} in_word_t;

	typedef struct packed {
		logic [31:0] data_out;
		logic        found;
		logic [1:0]  status;
		logic [4:0]  occupancy;
		logic        is_empty;
	} out_word_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_FIN
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic exec;
		logic scan;
		logic finish;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic need_scan;
		logic scan_last;
		logic out_free;
	} stat_t;

endpackage

/* sv/bdq_ctrl.sv */
module bdq_ctrl
	import bdq_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  stat_t  stat,
	output cmd_t   cmd
);

	state_t state_q;
	state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		cmd        = '0;
		in_ready   = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load   = 1'b1;
					state_next = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec   = 1'b1;
				state_next = stat.need_scan ? S_SCAN : S_FIN;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_last) begin
					state_next = S_FIN;
				end
			end
			S_FIN: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_next = S_IDLE;
				end
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

endmodule

/* sv/bdq_dpath.sv */
module bdq_dpath
	import bdq_pkg::*;
#(
	parameter int DEPTH     = 16,
	parameter int WORD_BITS = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cmd_t      cmd,
	output stat_t     stat,
	input  in_word_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_data
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = CW + 1;
	localparam int XW = (WORD_BITS > 32) ? 32 : WORD_BITS;

	logic [WORD_BITS-1:0] mem [DEPTH];
	logic [WORD_BITS-1:0] rd_q;
	logic [WORD_BITS-1:0] word_q;
	logic [2:0]           kind_q;
	logic [AW-1:0]        front_q;
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        scan_q;
	logic                 found_q;
	logic                 pop_ok_q;
	logic [1:0]           status_q;
	logic                 out_valid_q;
	out_word_t            out_q;

	logic                 is_full;
	logic                 is_empty;
	logic [AW-1:0]        front_dec;
	logic [AW-1:0]        front_inc;
	logic [CW-1:0]        rd_off;
	logic [AW-1:0]        rd_addr;
	logic [AW-1:0]        back_addr;
	logic                 rd_en;
	logic                 wr_en;
	logic [AW-1:0]        wr_addr;

	function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a, input logic [CW-1:0] b);
		logic [SW-1:0] s;
		s = SW'(a) + SW'(b);
		if (s >= SW'(DEPTH)) begin
			s = s - SW'(DEPTH);
		end
		return s[AW-1:0];
	endfunction

	assign is_full   = (count_q == CW'(DEPTH));
	assign is_empty  = (count_q == '0);
	assign front_dec = (front_q == '0) ? AW'(DEPTH - 1) : front_q - 1'b1;
	assign front_inc = (front_q == AW'(DEPTH - 1)) ? '0 : front_q + 1'b1;
	assign back_addr = ring_add(front_q, count_q);

	// One shared offset adder forms every read address: front pop, back pop, first search read and every scan step.
	always_comb begin
		if (cmd.exec) begin
			rd_off = (kind_q == KIND_POP_BACK) ? count_q - 1'b1 : '0;
		end else begin
			rd_off = scan_q;
		end
	end
	assign rd_addr = ring_add(front_q, rd_off);

	always_comb begin
		rd_en = 1'b0;
		if (cmd.scan && !stat.scan_last) begin
			rd_en = 1'b1;
		end else if (cmd.exec && !is_empty) begin
			case (kind_q)
				KIND_POP_FRONT, KIND_POP_BACK, KIND_SEARCH: rd_en = 1'b1;
				default:                                   rd_en = 1'b0;
			endcase
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = back_addr;
		if (cmd.exec && !is_full) begin
			case (kind_q)
				KIND_PUSH_FRONT: begin
					wr_en   = 1'b1;
					wr_addr = front_dec;
				end
				KIND_PUSH_BACK: begin
					wr_en = 1'b1;
				end
				default: begin
					wr_en = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= word_q;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= in_data.kind;
			word_q <= WORD_BITS'(in_data.data_in[XW-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
		end else if (cmd.exec) begin
			case (kind_q)
				KIND_PUSH_FRONT: begin
					if (!is_full) begin
						front_q <= front_dec;
						count_q <= count_q + 1'b1;
					end
				end
				KIND_PUSH_BACK: begin
					if (!is_full) begin
						count_q <= count_q + 1'b1;
					end
				end
				KIND_POP_FRONT: begin
					if (!is_empty) begin
						front_q <= front_inc;
						count_q <= count_q - 1'b1;
					end
				end
				KIND_POP_BACK: begin
					if (!is_empty) begin
						count_q <= count_q - 1'b1;
					end
				end
				KIND_CLEAR: begin
					front_q <= '0;
					count_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			found_q  <= 1'b0;
			scan_q   <= CW'(1);
			pop_ok_q <= 1'b0;
			status_q <= STAT_OK;
			case (kind_q)
				KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
					if (is_full) begin
						status_q <= STAT_FULL;
					end
				end
				KIND_POP_FRONT, KIND_POP_BACK: begin
					if (is_empty) begin
						status_q <= STAT_EMPTY;
					end else begin
						pop_ok_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end else if (cmd.scan) begin
			// The word read last cycle is the entry at offset scan_q - 1.
			if (rd_q == word_q) begin
				found_q <= 1'b1;
			end
			scan_q <= scan_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_q.data_out  <= pop_ok_q ? 32'(rd_q[XW-1:0]) : '0;
			out_q.found     <= found_q;
			out_q.status    <= status_q;
			out_q.occupancy <= 5'(count_q);
			out_q.is_empty  <= is_empty;
		end
	end

	assign stat.need_scan = (kind_q == KIND_SEARCH) && !is_empty;
	assign stat.scan_last = (scan_q == count_q);
	assign stat.out_free  = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

/* sv/bounded_deque_with_search.sv */
// Channel   Direction  Payload      Handshake
// in        input      in_word_t    in_valid / in_ready
// out       output     out_word_t   out_valid / out_ready
//
// A push, pop, clear or unused code passes three steps from acceptance to the
// result word: latch, execute against the slot memory, then load the output
// register. A search adds a scan of the stored words before the load, since
// the single read port of the slot memory delivers one stored word per cycle.
// Reset clears the front index, the count and all handshake state; the slot
// memory is not cleared. A stalled output keeps its result word while the
// block takes the next request; that request then waits before loading.
module bounded_deque_with_search
	import bdq_pkg::*;
#(
	parameter int DEPTH     = 16,
	parameter int WORD_BITS = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_word_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_data
);

	// Commands from the sequencer and status back from the datapath.
	cmd_t  cmd;
	stat_t stat;

	// The controller walks each request through execute, an optional scan of
	// the stored words, and the final load of the output register.
	bdq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// The datapath holds the ring of slots, the front index and count, the
	// search comparator and the output register.
	bdq_dpath #(
		.DEPTH     (DEPTH),
		.WORD_BITS (WORD_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// At most one command is issued in any cycle.
	assert property (@(posedge clk) disable iff (!arst_n) $onehot0(cmd))
		else $error("more than one datapath command at once");

	// The output register is loaded only when it is free or being emptied.
	assert property (@(posedge clk) disable iff (!arst_n) cmd.finish |-> stat.out_free)
		else $error("result loaded over a waiting word");

	// One request at a time: after an acceptance the input is not ready.
	assert property (@(posedge clk) disable iff (!arst_n) (in_valid && in_ready) |=> !in_ready)
		else $error("request accepted while another is in progress");

	// An error result never carries a popped word or a found flag.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.status != STAT_OK) |-> (out_data.data_out == '0 && !out_data.found))
		else $error("error result carries data");

endmodule
